@@ rtl/stte_pkg.sv @@
// ============================================================================
// stte_pkg
// Shared types and codes for the software timer table engine: command and
// result beats, controller-to-datapath command and status groups.
// ============================================================================
package stte_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;
    localparam logic [2:0] OP_CHPER  = 3'd5;

    // Result kinds and status codes
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_EXP = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_ERR   = 1'b1;

    // Only slots below this can be addressed by the 4-bit timer id
    localparam int ADDR_SLOTS = 16;

    // Command beat
    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  timer_id;
        logic [31:0] period;
        logic        auto_reload;
    } t_in;

    // Result beat
    typedef struct packed {
        logic       kind;
        logic [3:0] slot;
        logic       status;
        logic       running;
        logic       last;
    } t_out;

    // Controller -> datapath
    typedef struct packed {
        logic ld_in;      // capture command beat, clear scan index
        logic rd_cmd;     // read table at the command's slot
        logic exec_cmd;   // apply command, emit acknowledge
        logic exec_scan;  // count down one slot, read the next
        logic flush;      // emit held expiry with last set
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_tick;    // beat on the input port is a tick
        logic scan_last;  // scan index is at the final slot
    } t_dp_sts;

endpackage

@@ rtl/software_timer_table_engine_core.sv @@
// ============================================================================
// software_timer_table_engine_core
// Timer slot table with create/start/stop/reset/change-period commands and
// a tick that counts active slots down and reports expiries.
// ============================================================================
// A beat is taken when start is high and busy is low. A command passes
// through accept, table read and execute, and its single acknowledge
// appears with o_strobe on the cycle after execute. A tick passes through
// accept, a first table read, a scan step for each slot and flush: the
// scan visits one slot per cycle through the single read port of the
// count and period memories. Expiries come out in
// ascending slot order, each one strobe cycle; the final one carries last
// and arrives in the cycle after the flush cycle that follows the scan. A
// tick with no expiry gives no beat. Results are never held back: the
// receiver must take each o_strobe beat in its cycle.
module software_timer_table_engine_core #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  stte_pkg::t_in   i_cmd,
    output stte_pkg::t_out  o_res,
    output logic            o_strobe
);

    stte_pkg::t_dp_cmd ctl;
    stte_pkg::t_dp_sts sts;

    // Sequencer
    stte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (ctl)
    );

    // Table and arithmetic
    stte_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

endmodule

@@ rtl/stte_ctrl.sv @@
// ============================================================================
// stte_ctrl
// Sequencer: command read/execute, or tick scan over all slots then flush.
// ============================================================================
module stte_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  stte_pkg::t_dp_sts  i_sts,
    output stte_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CEX,
        S_TRD,
        S_TSCAN,
        S_TFLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = i_sts.in_tick ? S_TRD : S_CRD;
            S_CRD:    n_state = S_CEX;
            S_CEX:    n_state = S_IDLE;
            S_TRD:    n_state = S_TSCAN;
            S_TSCAN:  if (i_sts.scan_last) n_state = S_TFLUSH;
            S_TFLUSH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    // Datapath commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.ld_in     = (r_state == S_IDLE) && start;
        o_cmd.rd_cmd    = (r_state == S_CRD);
        o_cmd.exec_cmd  = (r_state == S_CEX);
        o_cmd.exec_scan = (r_state == S_TSCAN);
        o_cmd.flush     = (r_state == S_TFLUSH);
    end

    assign busy = r_busy;

    // Assertions
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy out of step with state");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TSCAN) && i_sts.scan_last |=> (r_state == S_TFLUSH))
        else $error("scan did not end in flush");

    a_cmd_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRD) |=> (r_state == S_CEX))
        else $error("command read not followed by execute");

endmodule

@@ rtl/stte_dp.sv @@
// ============================================================================
// stte_dp
// Timer table datapath: count and period memories, active/mode bits,
// command execution, tick count-down with held expiry for last marking.
// ============================================================================
module stte_dp #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stte_pkg::t_in      i_cmd,
    input  stte_pkg::t_dp_cmd  i_ctl,
    output stte_pkg::t_dp_sts  o_sts,
    output stte_pkg::t_out     o_res,
    output logic               o_strobe
);

    // Slots a 4-bit id can reach; higher ones never run
    localparam int ACT_SLOTS = (NUM_SLOTS < stte_pkg::ADDR_SLOTS) ?
                               NUM_SLOTS : stte_pkg::ADDR_SLOTS;
    localparam int SLOT_W    = $clog2(ACT_SLOTS);
    localparam logic [TICK_BITS-1:0] ONE_T = TICK_BITS'(1);

    // Table storage
    logic [TICK_BITS-1:0] r_cnt_mem [ACT_SLOTS];
    logic [TICK_BITS-1:0] r_per_mem [ACT_SLOTS];
    logic [ACT_SLOTS-1:0] r_per_vld;
    logic [ACT_SLOTS-1:0] r_mode;
    logic [ACT_SLOTS-1:0] r_act;

    logic [TICK_BITS-1:0] r_cnt_rd, r_per_rd;
    logic                 r_pv_rd;

    stte_pkg::t_in        r_in;
    logic [SLOT_W-1:0]    r_idx;
    stte_pkg::t_out       r_out, n_out;
    logic                 r_strobe, n_strobe;

    // Held expiry, emitted once the next one (or the scan end) is seen
    logic                 r_hold_vld, n_hold_vld;
    logic [SLOT_W-1:0]    r_hold_slot, n_hold_slot;
    logic                 r_hold_run, n_hold_run;

    logic [SLOT_W-1:0]    id_idx, rd_addr, wr_addr;
    logic [TICK_BITS-1:0] per_cut, per_rd, cnt_dec, cnt_wd;
    logic                 id_bad, err, we_cnt, we_per, we_mode, we_act, act_wd;
    logic                 cur_act;

    assign id_idx  = r_in.timer_id[SLOT_W-1:0];
    assign per_cut = TICK_BITS'(r_in.period);
    assign per_rd  = r_pv_rd ? r_per_rd : '0;
    assign cnt_dec = r_cnt_rd - ONE_T;
    assign id_bad  = (32'(r_in.timer_id) >= 32'(NUM_SLOTS));
    assign rd_addr = i_ctl.rd_cmd ? id_idx :
                     (i_ctl.exec_scan ? SLOT_W'(r_idx + 1'b1) : r_idx);
    assign wr_addr = i_ctl.exec_cmd ? id_idx : r_idx;
    assign cur_act = i_ctl.exec_cmd ? r_act[id_idx] : r_act[r_idx];

    assign o_sts.in_tick   = (i_cmd.operation == stte_pkg::OP_TICK);
    assign o_sts.scan_last = (r_idx == SLOT_W'(ACT_SLOTS - 1));

    // Command execution, tick count-down and expiry flush
    always_comb begin
        err         = stte_pkg::ST_OK;
        we_cnt      = 1'b0;
        we_per      = 1'b0;
        we_mode     = 1'b0;
        we_act      = 1'b0;
        act_wd      = cur_act;
        cnt_wd      = '0;
        n_out       = r_out;
        n_strobe    = 1'b0;
        n_hold_vld  = r_hold_vld;
        n_hold_slot = r_hold_slot;
        n_hold_run  = r_hold_run;

        if (i_ctl.exec_cmd) begin
            if (id_bad) begin
                err = stte_pkg::ST_ERR;
            end else begin
                case (r_in.operation)
                    stte_pkg::OP_CREATE: begin
                        if (per_cut == '0) begin
                            err = stte_pkg::ST_ERR;
                        end else begin
                            we_per  = 1'b1;
                            we_mode = 1'b1;
                            we_cnt  = 1'b1;
                            cnt_wd  = '0;
                            we_act  = 1'b1;
                            act_wd  = 1'b0;
                        end
                    end
                    stte_pkg::OP_START: begin
                        if (per_rd == '0) begin
                            err = stte_pkg::ST_ERR;
                        end else begin
                            we_cnt = 1'b1;
                            cnt_wd = per_rd;
                            we_act = 1'b1;
                            act_wd = 1'b1;
                        end
                    end
                    stte_pkg::OP_STOP: begin
                        we_act = 1'b1;
                        act_wd = 1'b0;
                    end
                    stte_pkg::OP_RESET: begin
                        we_cnt = cur_act;
                        cnt_wd = per_rd;
                    end
                    stte_pkg::OP_CHPER: begin
                        if (per_cut == '0) begin
                            err = stte_pkg::ST_ERR;
                        end else begin
                            we_per = 1'b1;
                            we_cnt = cur_act;
                            cnt_wd = per_cut;
                        end
                    end
                    // unknown operation reports not running, slot untouched
                    default: begin
                        err    = stte_pkg::ST_ERR;
                        act_wd = 1'b0;
                    end
                endcase
            end
            n_out.kind    = stte_pkg::KIND_ACK;
            n_out.slot    = r_in.timer_id;
            n_out.status  = err;
            n_out.running = id_bad ? 1'b0 : act_wd;
            n_out.last    = 1'b1;
            n_strobe      = 1'b1;
        end else if (i_ctl.exec_scan) begin
            if (cur_act) begin
                we_cnt = 1'b1;
                cnt_wd = cnt_dec;
                if (cnt_dec == '0) begin
                    if (r_mode[r_idx]) begin
                        cnt_wd = per_rd;
                    end else begin
                        we_act = 1'b1;
                        act_wd = 1'b0;
                    end
                    // Release the previous expiry, hold this one
                    if (r_hold_vld) begin
                        n_out.kind    = stte_pkg::KIND_EXP;
                        n_out.slot    = 4'(r_hold_slot);
                        n_out.status  = stte_pkg::ST_OK;
                        n_out.running = r_hold_run;
                        n_out.last    = 1'b0;
                        n_strobe      = 1'b1;
                    end
                    n_hold_vld  = 1'b1;
                    n_hold_slot = r_idx;
                    n_hold_run  = act_wd;
                end
            end
        end else if (i_ctl.flush) begin
            if (r_hold_vld) begin
                n_out.kind    = stte_pkg::KIND_EXP;
                n_out.slot    = 4'(r_hold_slot);
                n_out.status  = stte_pkg::ST_OK;
                n_out.running = r_hold_run;
                n_out.last    = 1'b1;
                n_strobe      = 1'b1;
            end
            n_hold_vld = 1'b0;
        end
    end

    // Count memory
    always_ff @(posedge i_clk) begin
        if (we_cnt) r_cnt_mem[wr_addr] <= cnt_wd;
        r_cnt_rd <= r_cnt_mem[rd_addr];
    end

    // Period memory
    always_ff @(posedge i_clk) begin
        if (we_per) r_per_mem[wr_addr] <= per_cut;
        r_per_rd <= r_per_mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) r_in <= i_cmd;
        r_out       <= n_out;
        r_pv_rd     <= r_per_vld[rd_addr];
        r_hold_slot <= n_hold_slot;
        r_hold_run  <= n_hold_run;
    end

    // Control and per-slot flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_vld  <= '0;
            r_mode     <= '0;
            r_act      <= '0;
            r_strobe   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (we_per)  r_per_vld[wr_addr] <= 1'b1;
            if (we_mode) r_mode[wr_addr]    <= r_in.auto_reload;
            if (we_act)  r_act[wr_addr]     <= act_wd;
            r_strobe   <= n_strobe;
            r_hold_vld <= n_hold_vld;
            if (i_ctl.ld_in) begin
                r_idx <= '0;
            end else if (i_ctl.exec_scan) begin
                r_idx <= SLOT_W'(r_idx + 1'b1);
            end
        end
    end

    assign o_res    = r_out;
    assign o_strobe = r_strobe;

    // Assertions
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_out.kind == stte_pkg::KIND_ACK) |-> r_out.last)
        else $error("acknowledge without last");

    a_ack_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec_cmd |=> r_strobe)
        else $error("command produced no acknowledge");

    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld_in |-> !r_hold_vld)
        else $error("held expiry left over at new item");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> !r_hold_vld)
        else $error("held expiry survived flush");

endmodule
